@@ sv/gblur_pkg.sv @@
// shared constants, types and kernel table of the 7x7 gaussian blur stream
// no dependencies; every other file imports this package
`default_nettype none

package gblur_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int CFG_W     = 12;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;
  localparam int HGT_W     = CFG_W;
  localparam int CNT_W     = WID_W + HGT_W;
  localparam int DLY_W     = WID_W + 2;
  localparam int PIX_W     = 8;
  localparam int KSIZE     = 7;
  localparam int KHALF     = 3;
  localparam int LINES     = KSIZE - 1;
  localparam int TAP_W     = 10;
  localparam int FRAC_BITS = 14;
  localparam int ROW_W     = PIX_W + TAP_W + 3;
  localparam int SUM_W     = ROW_W + 3;
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd1080;

  localparam logic [TAP_W-1:0] TAPS [4][4] = '{
    '{10'd80,  10'd150, 10'd219, 10'd248},
    '{10'd150, 10'd281, 10'd409, 10'd464},
    '{10'd219, 10'd409, 10'd595, 10'd675},
    '{10'd248, 10'd464, 10'd675, 10'd765}
  };

  typedef logic [KSIZE-1:0][PIX_W-1:0] column_t;

  typedef struct packed {
    logic             valid;
    logic             has_out;
    logic             last;
    logic [KSIZE-1:0] rmask;
    logic [KSIZE-1:0] cmask;
  } pipe_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] blurred;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] quotient;
    logic [WID_W-1:0] remainder;
  } div_res_t;

  function automatic logic [TAP_W-1:0] kernel_tap(input int y, input int x);
    int ry;
    int rx;
    ry = (y > KHALF) ? (KSIZE - 1 - y) : y;
    rx = (x > KHALF) ? (KSIZE - 1 - x) : x;
    return TAPS[2'(ry)][2'(rx)];
  endfunction

  function automatic logic [WID_W-1:0] eff_width(input logic [CFG_W-1:0] fw);
    if (fw == '0) return WID_W'(1);
    if (int'(fw) > MAX_WIDTH) return WID_W'(MAX_WIDTH);
    return WID_W'(fw);
  endfunction

  function automatic logic [HGT_W-1:0] eff_height(input logic [CFG_W-1:0] fh);
    if (fh == '0) return HGT_W'(1);
    return HGT_W'(fh);
  endfunction

endpackage

`default_nettype wire

@@ sv/gaussian_blur_7x7_stream.sv @@
// top level of the 7x7 gaussian blur stream: frame counters, config
// registers and wiring; depends on gblur_pkg, gblur_lbuf, gblur_conv,
// gblur_div and gblur_outq
//
// usage:
//   in_*  : one request per pixel in raster order; in_tuser = 1 marks a
//           padding tick (sample reads as zero). after each frame send
//           3*width+3 padding ticks to flush the window.
//   out_* : one filtered pixel per result, out_tlast on the last of a frame.
//   cfg_* : write frame_width (index 0) or frame_height (index 1) while idle.
//   throughput is one request per clock while in_tready is high; the first
//   result of a frame needs 3*width+3 earlier requests, then each request
//   yields one result. a request's result reaches out_tvalid after the
//   window shift, the row sums and the final sum into the queue.
//   after reset in_tready stays low while the line store is cleared one
//   column per cycle; after a config write it stays low while the output
//   row and column are recomputed by a serial divider. a stalled receiver
//   fills an 8-entry result queue; in_tready drops only once queued plus
//   in-flight results would overflow it.
`default_nettype none

module gaussian_blur_7x7_stream (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gblur_pkg::PIX_W-1:0]   in_tdata,   // [7:0] pixel
  input  logic                          in_tuser,   // [0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gblur_pkg::PIX_W-1:0]   out_tdata,  // [7:0] blurred
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gblur_pkg::CFG_W-1:0]   cfg_wdata
);
  import gblur_pkg::*;

  localparam int RW = HGT_W + 1;

  logic [CFG_W-1:0]    frame_width_r;
  logic [CFG_W-1:0]    frame_height_r;
  logic                cfg_pend_r;
  logic [WID_W-1:0]    w_eff;
  logic [HGT_W-1:0]    h_eff;
  logic [CNT_W-1:0]    total_r;
  logic [DLY_W-1:0]    delay_r;

  logic [COL_W-1:0]    col_r, col_nxt, col0, col_inc;
  logic [DLY_W-1:0]    acc_r, acc_nxt, acc0;
  logic [CNT_W-1:0]    emitted_r, emitted_nxt, e0;
  logic [HGT_W-1:0]    erow_r, erow_nxt, r0;
  logic [COL_W-1:0]    ecol_r, ecol_nxt, c0;
  logic                restart;
  pipe_ctl_t           ctl_nxt;
  pipe_ctl_t           s1_ctl_r;

  logic                accept;
  logic [PIX_W-1:0]    sample;
  logic                lb_clearing;
  logic                lb_col_valid;
  column_t             lb_col;
  res_t                push;
  logic [1:0]          conv_inflight;
  div_res_t            div_res;
  logic [OQ_CNT_W-1:0] oq_count;
  logic [OQ_CNT_W:0]   credit;

  assign w_eff = eff_width(frame_width_r);
  assign h_eff = eff_height(frame_height_r);

  assign credit = {1'b0, oq_count} + (OQ_CNT_W+1)'(s1_ctl_r.valid && s1_ctl_r.has_out)
                + (OQ_CNT_W+1)'(conv_inflight);

  assign in_tready = !lb_clearing && !cfg_pend_r && !div_res.busy &&
                     (credit < (OQ_CNT_W+1)'(OQ_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign sample    = in_tuser ? '0 : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      cfg_pend_r     <= 1'b0;
    end else begin
      cfg_pend_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  frame_width_r  <= cfg_wdata;
          REG_HEIGHT: frame_height_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= CNT_W'(w_eff) * CNT_W'(h_eff);
    delay_r <= DLY_W'(w_eff) + DLY_W'({w_eff, 1'b0}) + DLY_W'(3);
  end

  // per-request counter update and boundary masks
  always_comb begin
    restart = emitted_r >= total_r;
    e0   = restart ? '0 : emitted_r;
    r0   = restart ? '0 : erow_r;
    c0   = restart ? '0 : ecol_r;
    acc0 = restart ? '0 : acc_r;
    col0 = restart ? '0 : col_r;
    if ({1'b0, col0} >= w_eff) col0 = '0;
    col_inc = (({1'b0, col0} + WID_W'(1)) >= w_eff) ? '0 : col0 + COL_W'(1);

    ctl_nxt.valid   = 1'b1;
    ctl_nxt.has_out = acc0 >= delay_r;
    ctl_nxt.last    = ctl_nxt.has_out && ((e0 + CNT_W'(1)) == total_r);
    for (int k = 0; k < KSIZE; k++) begin
      if (k < KHALF) begin
        ctl_nxt.rmask[k] = r0 >= HGT_W'(KHALF - k);
        ctl_nxt.cmask[k] = c0 >= COL_W'(KHALF - k);
      end else if (k == KHALF) begin
        ctl_nxt.rmask[k] = 1'b1;
        ctl_nxt.cmask[k] = 1'b1;
      end else begin
        ctl_nxt.rmask[k] = ({1'b0, r0} + RW'(k - KHALF)) < {1'b0, h_eff};
        ctl_nxt.cmask[k] = ({1'b0, c0} + WID_W'(k - KHALF)) < w_eff;
      end
    end

    col_nxt     = col_inc;
    acc_nxt     = acc0;
    emitted_nxt = e0;
    erow_nxt    = r0;
    ecol_nxt    = c0;
    if (!ctl_nxt.has_out) begin
      acc_nxt = acc0 + DLY_W'(1);
    end else if (ctl_nxt.last) begin
      col_nxt     = '0;
      acc_nxt     = '0;
      emitted_nxt = '0;
      erow_nxt    = '0;
      ecol_nxt    = '0;
    end else begin
      emitted_nxt = e0 + CNT_W'(1);
      if (({1'b0, c0} + WID_W'(1)) == w_eff) begin
        ecol_nxt = '0;
        erow_nxt = r0 + HGT_W'(1);
      end else begin
        ecol_nxt = c0 + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      acc_r     <= '0;
      emitted_r <= '0;
      erow_r    <= '0;
      ecol_r    <= '0;
      s1_ctl_r  <= '0;
    end else begin
      s1_ctl_r <= accept ? ctl_nxt : '0;
      if (accept) begin
        col_r     <= col_nxt;
        acc_r     <= acc_nxt;
        emitted_r <= emitted_nxt;
        erow_r    <= erow_nxt;
        ecol_r    <= ecol_nxt;
      end else if (div_res.done) begin
        erow_r <= HGT_W'(div_res.quotient);
        ecol_r <= COL_W'(div_res.remainder);
      end
    end
  end

  gblur_lbuf u_lbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_valid  (accept),
    .acc_col    (col0),
    .acc_sample (sample),
    .clearing   (lb_clearing),
    .col_valid  (lb_col_valid),
    .col_data   (lb_col)
  );

  pipe_ctl_t conv_ctl;

  always_comb begin
    conv_ctl       = s1_ctl_r;
    conv_ctl.valid = s1_ctl_r.valid && lb_col_valid;
  end

  gblur_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (conv_ctl),
    .col_data (lb_col),
    .push     (push),
    .inflight (conv_inflight)
  );

  gblur_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_pend_r),
    .dividend (emitted_r),
    .divisor  (w_eff),
    .res      (div_res)
  );

  gblur_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .count      (oq_count)
  );

endmodule

`default_nettype wire

@@ sv/gblur_lbuf.sv @@
// six-line store as one column-wide memory, with clearing pass after reset
// and same-column bypass; depends on gblur_pkg
`default_nettype none

module gblur_lbuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc_valid,
  input  logic [gblur_pkg::COL_W-1:0]   acc_col,
  input  logic [gblur_pkg::PIX_W-1:0]   acc_sample,
  output logic                          clearing,
  output logic                          col_valid,
  output gblur_pkg::column_t            col_data
);
  import gblur_pkg::*;

  localparam int WORD_W = LINES * PIX_W;

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] byp_word_r;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] wr_data;
  logic              byp_r;
  logic              s1_valid_r;
  logic              clear_r;
  logic              we;
  logic [COL_W-1:0]  s1_col_r;
  logic [COL_W-1:0]  clr_addr_r;
  logic [COL_W-1:0]  wr_addr;
  logic [PIX_W-1:0]  s1_sample_r;

  assign cur_word = byp_r ? byp_word_r : rd_data_r;
  assign new_word = {s1_sample_r, cur_word[WORD_W-1:PIX_W]};

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col_data[k] = cur_word[k*PIX_W +: PIX_W];
    end
    col_data[KSIZE-1] = s1_sample_r;
  end

  assign we      = clear_r || s1_valid_r;
  assign wr_addr = clear_r ? clr_addr_r : s1_col_r;
  assign wr_data = clear_r ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc_valid) begin
      rd_data_r <= mem[acc_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      s1_valid_r <= acc_valid;
      if (acc_valid) begin
        byp_r <= s1_valid_r && (s1_col_r == acc_col);
      end
      if (clear_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == '1) begin
          clear_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid) begin
      s1_col_r    <= acc_col;
      s1_sample_r <= acc_sample;
      byp_word_r  <= new_word;
    end
  end

  assign clearing  = clear_r;
  assign col_valid = s1_valid_r;

endmodule

`default_nettype wire

@@ sv/gblur_conv.sv @@
// 7x7 window register, masked row sums and final sum with truncation and
// saturation; depends on gblur_pkg
`default_nettype none

module gblur_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gblur_pkg::pipe_ctl_t  ctl_in,
  input  gblur_pkg::column_t    col_data,
  output gblur_pkg::res_t       push,
  output logic [1:0]            inflight
);
  import gblur_pkg::*;

  logic [PIX_W-1:0]           win_r [KSIZE][KSIZE];
  pipe_ctl_t                  s2_r;
  pipe_ctl_t                  s3_r;
  logic [ROW_W-1:0]           row_sum_r [KSIZE];
  logic [ROW_W-1:0]           row_nxt [KSIZE];
  logic [SUM_W-1:0]           total;
  logic [SUM_W-FRAC_BITS-1:0] scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < KSIZE; y++) begin
        for (int x = 0; x < KSIZE; x++) begin
          win_r[y][x] <= '0;
        end
      end
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      if (ctl_in.valid) begin
        for (int y = 0; y < KSIZE; y++) begin
          for (int x = 0; x < KSIZE - 1; x++) begin
            win_r[y][x] <= win_r[y][x+1];
          end
          win_r[y][KSIZE-1] <= col_data[y];
        end
      end
      s2_r <= ctl_in;
      s3_r <= s2_r;
    end
  end

  // per-row sums over the window as it stands after this item's shift
  always_comb begin
    logic [ROW_W-1:0] racc;
    for (int y = 0; y < KSIZE; y++) begin
      racc = '0;
      for (int x = 0; x < KSIZE; x++) begin
        if (s2_r.cmask[x]) begin
          racc = racc + ROW_W'(win_r[y][x]) * ROW_W'(kernel_tap(y, x));
        end
      end
      row_nxt[y] = s2_r.rmask[y] ? racc : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int y = 0; y < KSIZE; y++) begin
      row_sum_r[y] <= row_nxt[y];
    end
  end

  always_comb begin
    total = '0;
    for (int y = 0; y < KSIZE; y++) begin
      total = total + SUM_W'(row_sum_r[y]);
    end
  end

  assign scaled = total[SUM_W-1:FRAC_BITS];

  assign push.valid   = s3_r.valid && s3_r.has_out;
  assign push.last    = s3_r.last;
  assign push.blurred = (|scaled[SUM_W-FRAC_BITS-1:PIX_W]) ? '1 : scaled[PIX_W-1:0];

  assign inflight = {1'b0, s2_r.valid && s2_r.has_out} +
                    {1'b0, s3_r.valid && s3_r.has_out};

endmodule

`default_nettype wire

@@ sv/gblur_div.sv @@
// restoring divider, one quotient bit per cycle, for recomputing the output
// row and column after a config write; depends on gblur_pkg
`default_nettype none

module gblur_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gblur_pkg::CNT_W-1:0]   dividend,
  input  logic [gblur_pkg::WID_W-1:0]   divisor,
  output gblur_pkg::div_res_t           res
);
  import gblur_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              done_r;
  logic [CNT_W-1:0]  quo_r;
  logic [WID_W-1:0]  rem_r;
  logic [WID_W-1:0]  dvs_r;
  logic [WID_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[CNT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= STEP_W'(CNT_W);
      end else if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[CNT_W-2:0], fits};
      rem_r <= fits ? WID_W'(trial - {1'b0, dvs_r}) : trial[WID_W-1:0];
    end
  end

  assign res.busy      = (step_r != '0) || done_r;
  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

`default_nettype wire

@@ sv/gblur_outq.sv @@
// small result queue in front of the output stream, with fill count for
// input-side credit; depends on gblur_pkg
`default_nettype none

module gblur_outq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gblur_pkg::res_t                  push,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [gblur_pkg::PIX_W-1:0]      out_tdata,
  output logic                             out_tlast,
  output logic [gblur_pkg::OQ_CNT_W-1:0]   count
);
  import gblur_pkg::*;

  logic [PIX_W:0]    data_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic              pop;

  assign out_tvalid = cnt_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = data_r[rd_ptr_r][PIX_W:1];
  assign out_tlast  = data_r[rd_ptr_r][0];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      data_r[wr_ptr_r] <= {push.blurred, push.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
      if (push.valid && !pop) begin
        cnt_r <= cnt_r + OQ_CNT_W'(1);
      end else if (!push.valid && pop) begin
        cnt_r <= cnt_r - OQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
